// ===== rtl/fbs_pkg.sv =====
package fbs_pkg;

  // result status, first failing check wins
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_SECTOR_SIZE = 3'd1,
    ST_BAD_CLUSTER    = 3'd2,
    ST_SMALL_SIZE_SET = 3'd3,
    ST_BAD_MEDIA      = 3'd4
  } status_t;

  // byte offsets inside the boot sector that the parser cares about
  localparam int OFS_W = 5;
  localparam logic [OFS_W-1:0] OFS_BPS_LO    = 5'h0B;
  localparam logic [OFS_W-1:0] OFS_BPS_HI    = 5'h0C;
  localparam logic [OFS_W-1:0] OFS_SPC       = 5'h0D;
  localparam logic [OFS_W-1:0] OFS_RSV_LO    = 5'h0E;
  localparam logic [OFS_W-1:0] OFS_RSV_HI    = 5'h0F;
  localparam logic [OFS_W-1:0] OFS_NFATS     = 5'h10;
  localparam logic [OFS_W-1:0] OFS_ROOT_LO   = 5'h11;
  localparam logic [OFS_W-1:0] OFS_ROOT_HI   = 5'h12;
  localparam logic [OFS_W-1:0] OFS_TOT16_LO  = 5'h13;
  localparam logic [OFS_W-1:0] OFS_TOT16_HI  = 5'h14;
  localparam logic [OFS_W-1:0] OFS_MEDIA     = 5'h15;
  localparam logic [OFS_W-1:0] OFS_SPF_LO    = 5'h16;
  localparam logic [OFS_W-1:0] OFS_SPF_HI    = 5'h17;

  localparam logic [15:0] SECTOR_BYTES = 16'd512;
  localparam logic [7:0]  MEDIA_FIXED  = 8'hF8;

  // root entries / 16 minus two clusters, signed
  localparam int ADJ_W = 14;

  // request handed from the parse stage to the geometry stage
  typedef struct packed {
    status_t                   status;
    logic [32:0]               fat_lba;
    logic [23:0]               fat_span;
    logic signed [ADJ_W-1:0]   base_adj;
    logic [7:0]                spc;
    logic [7:0]                copies;
    logic [15:0]               root_entries;
    logic [15:0]               spf;
  } geom_req_t;

endpackage

// ===== rtl/fbs_parse.sv =====
module fbs_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_byte,
  input  logic [31:0]         partition_start,
  output logic                req_valid,
  input  logic                req_ready,
  output fbs_pkg::geom_req_t  req
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;

  // parse state
  logic [fbs_pkg::OFS_W-1:0] offset_r, offset_nxt;
  logic                      done_r, done_nxt;
  logic [7:0]                hold_r, hold_nxt;
  fbs_pkg::status_t          err_r, err_nxt;
  logic [7:0]                spc_r, spc_nxt;
  logic [15:0]               rsv_r, rsv_nxt;
  logic [7:0]                copies_r, copies_nxt;
  logic [15:0]               roots_r, roots_nxt;

  // request register
  logic                 req_valid_r, req_valid_nxt;
  fbs_pkg::geom_req_t   req_r, req_nxt;

  logic                      eff_done;
  logic [fbs_pkg::OFS_W-1:0] eff_offset;
  fbs_pkg::status_t          eff_err;
  logic [15:0]               word;
  logic                      emit;
  logic                      s1_move;
  logic                      in_take;

  // first byte restarts at offset 0 with a clean error
  assign eff_done   = s1_first_r ? 1'b0 : done_r;
  assign eff_offset = s1_first_r ? '0 : offset_r;
  assign eff_err    = s1_first_r ? fbs_pkg::ST_OK : err_r;
  assign word       = {s1_byte_r, hold_r};
  assign emit       = !eff_done && (eff_offset == fbs_pkg::OFS_SPF_HI);

  assign s1_move  = s1_valid_r && (!emit || !req_valid_r || req_ready);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    offset_nxt = eff_offset;
    done_nxt   = eff_done;
    hold_nxt   = hold_r;
    err_nxt    = eff_err;
    spc_nxt    = spc_r;
    rsv_nxt    = rsv_r;
    copies_nxt = copies_r;
    roots_nxt  = roots_r;
    if (!eff_done) begin
      unique case (eff_offset) inside
        fbs_pkg::OFS_BPS_LO, fbs_pkg::OFS_RSV_LO, fbs_pkg::OFS_ROOT_LO,
        fbs_pkg::OFS_TOT16_LO, fbs_pkg::OFS_SPF_LO: begin
          hold_nxt = s1_byte_r;
        end
        fbs_pkg::OFS_BPS_HI: begin
          if (word != fbs_pkg::SECTOR_BYTES && eff_err == fbs_pkg::ST_OK) begin
            err_nxt = fbs_pkg::ST_BAD_SECTOR_SIZE;
          end
        end
        fbs_pkg::OFS_SPC: begin
          spc_nxt = s1_byte_r;
          if ((s1_byte_r == 8'd0 || s1_byte_r[0]) && eff_err == fbs_pkg::ST_OK) begin
            err_nxt = fbs_pkg::ST_BAD_CLUSTER;
          end
        end
        fbs_pkg::OFS_RSV_HI: begin
          rsv_nxt = word;
        end
        fbs_pkg::OFS_NFATS: begin
          copies_nxt = s1_byte_r;
        end
        fbs_pkg::OFS_ROOT_HI: begin
          roots_nxt = word;
        end
        fbs_pkg::OFS_TOT16_HI: begin
          if (word != 16'd0 && eff_err == fbs_pkg::ST_OK) begin
            err_nxt = fbs_pkg::ST_SMALL_SIZE_SET;
          end
        end
        fbs_pkg::OFS_MEDIA: begin
          if (s1_byte_r != fbs_pkg::MEDIA_FIXED && eff_err == fbs_pkg::ST_OK) begin
            err_nxt = fbs_pkg::ST_BAD_MEDIA;
          end
        end
        default: begin
        end
      endcase
      if (eff_offset == fbs_pkg::OFS_SPF_HI) begin
        done_nxt = 1'b1;
      end else begin
        offset_nxt = eff_offset + 1'b1;
      end
    end
  end

  // geometry terms that are ready at the last byte
  always_comb begin
    req_nxt.status       = eff_err;
    req_nxt.fat_lba      = {1'b0, partition_start} + {17'd0, rsv_r};
    req_nxt.fat_span     = {16'd0, copies_r} * {8'd0, word};
    req_nxt.base_adj     = $signed({2'b00, roots_r[15:4]})
                           - $signed({5'd0, spc_r, 1'b0});
    req_nxt.spc          = spc_r;
    req_nxt.copies       = copies_r;
    req_nxt.root_entries = roots_r;
    req_nxt.spf          = word;
  end

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (s1_move && emit) begin
      req_valid_nxt = 1'b1;
    end else if (req_ready) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      req_valid_r <= 1'b0;
      offset_r    <= '0;
      done_r      <= 1'b1;
      hold_r      <= '0;
      err_r       <= fbs_pkg::ST_OK;
      spc_r       <= '0;
      rsv_r       <= '0;
      copies_r    <= '0;
      roots_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      req_valid_r <= req_valid_nxt;
      if (s1_move) begin
        offset_r <= offset_nxt;
        done_r   <= done_nxt;
        hold_r   <= hold_nxt;
        err_r    <= err_nxt;
        spc_r    <= spc_nxt;
        rsv_r    <= rsv_nxt;
        copies_r <= copies_nxt;
        roots_r  <= roots_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
    end
    if (s1_move && emit) begin
      req_r <= req_nxt;
    end
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

  // a request only leaves the parser together with parse completion at byte 0x17
  a_req_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(req_valid_r) |-> done_r)
    else $error("request issued without parse completion");

  // parsing only restarts from a first byte
  a_restart_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(done_r) |-> $past(s1_first_r))
    else $error("parse restarted without first byte");

endmodule

// ===== rtl/fbs_geom.sv =====
module fbs_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  fbs_pkg::geom_req_t  req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [32:0]         out_fat_start_sector,
  output logic [32:0]         out_root_start_sector,
  output logic signed [33:0]  out_cluster_base_sector,
  output logic [7:0]          out_sectors_per_cluster,
  output logic [7:0]          out_fat_copies,
  output logic [15:0]         out_root_entry_count,
  output logic [15:0]         out_sectors_per_fat,
  output logic [11:0]         out_entries_per_cluster
);

  logic               valid_r, valid_nxt;
  logic [2:0]         status_r;
  logic [32:0]        fat_r, root_r;
  logic signed [33:0] base_r;
  logic [7:0]         spc_r, copies_r;
  logic [15:0]        roots_r, spf_r;
  logic [11:0]        epc_r;

  logic        ok;
  logic        take;
  logic [32:0] root_sum;
  logic [33:0] base_sum;

  assign req_ready = !valid_r || !out_stall;
  assign take      = req_valid && req_ready;
  assign ok        = (req.status == fbs_pkg::ST_OK);

  assign root_sum = req.fat_lba + {9'd0, req.fat_span};
  assign base_sum = {1'b0, root_sum}
                    + {{(34 - fbs_pkg::ADJ_W){req.base_adj[fbs_pkg::ADJ_W-1]}}, req.base_adj};

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // failed checks report zeros in every geometry field
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= req.status;
      fat_r    <= ok ? req.fat_lba : '0;
      root_r   <= ok ? root_sum : '0;
      base_r   <= ok ? $signed(base_sum) : '0;
      spc_r    <= ok ? req.spc : '0;
      copies_r <= ok ? req.copies : '0;
      roots_r  <= ok ? req.root_entries : '0;
      spf_r    <= ok ? req.spf : '0;
      epc_r    <= ok ? {req.spc, 4'd0} : '0;
    end
  end

  assign out_valid               = valid_r;
  assign out_status              = status_r;
  assign out_fat_start_sector    = fat_r;
  assign out_root_start_sector   = root_r;
  assign out_cluster_base_sector = base_r;
  assign out_sectors_per_cluster = spc_r;
  assign out_fat_copies          = copies_r;
  assign out_root_entry_count    = roots_r;
  assign out_sectors_per_fat     = spf_r;
  assign out_entries_per_cluster = epc_r;

  a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && status_r != fbs_pkg::ST_OK |-> fat_r == '0 && root_r == '0 && spf_r == '0)
    else $error("geometry not cleared on failed check");

  a_epc_match: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> epc_r == {spc_r, 4'd0})
    else $error("entries per cluster mismatch");

endmodule

// ===== rtl/fat16_boot_sector_parser.sv =====
// FAT16 boot sector parser: feed the 512 bytes of a boot sector one per request on the in_
// channel, with in_first_byte set on the byte at offset 0 (it restarts parsing at any time).
// Bytes 0x0B..0x17 are captured and checked; one result request appears on the out_ channel
// after byte 0x17, carrying the first failing check as out_status or, on success, the FAT,
// root directory and cluster base sectors offset by partition_start. Bytes after 0x17 and
// bytes before the first first_byte after reset give no result. One byte is taken per clock
// unless in_stall is high; a byte passes the input register, the request register and the
// output register before out_valid rises. The input only stalls when byte 0x17 waits in the
// input register while the request and output registers both still hold results under
// out_stall. partition_start is written on the cfg_ channel, always ready, and should only
// change while no sector is being parsed.
module fat16_boot_sector_parser (
  input  logic               clk,
  input  logic               rst_n,
  // byte channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [32:0]        out_fat_start_sector,
  output logic [32:0]        out_root_start_sector,
  output logic signed [33:0] out_cluster_base_sector,
  output logic [7:0]         out_sectors_per_cluster,
  output logic [7:0]         out_fat_copies,
  output logic [15:0]        out_root_entry_count,
  output logic [15:0]        out_sectors_per_fat,
  output logic [11:0]        out_entries_per_cluster,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_partition_start
);

  // partition start sector, added to every computed position
  logic [31:0] part_start_r;

  logic               req_valid;
  logic               req_ready;
  fbs_pkg::geom_req_t req;

  // register write never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      part_start_r <= cfg_partition_start;
    end
  end

  // byte capture, field checks, fat start and fat span product
  fbs_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .partition_start (part_start_r),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req)
  );

  // root and cluster base sums into the output register
  fbs_geom u_geom (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .req_valid               (req_valid),
    .req_ready               (req_ready),
    .req                     (req),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_fat_start_sector    (out_fat_start_sector),
    .out_root_start_sector   (out_root_start_sector),
    .out_cluster_base_sector (out_cluster_base_sector),
    .out_sectors_per_cluster (out_sectors_per_cluster),
    .out_fat_copies          (out_fat_copies),
    .out_root_entry_count    (out_root_entry_count),
    .out_sectors_per_fat     (out_sectors_per_fat),
    .out_entries_per_cluster (out_entries_per_cluster)
  );

  // status codes above bad media are never produced
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= fbs_pkg::ST_BAD_MEDIA)
    else $error("result status out of range");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // one expected result request, field for field as on the out_ ports
  typedef struct packed {
    fbs_pkg::status_t status;
    logic [32:0] fat_lba;
    logic [32:0] root_lba;
    logic [33:0] data_lba;
    logic [7:0]  spc;
    logic [7:0]  copies;
    logic [15:0] root_entries;
    logic [15:0] spf;
    logic [11:0] entries_per_cluster;
  } boot_geom_t;

  // one boot sector to send: noise before it, where to cut it short, bytes past 0x17
  typedef struct packed {
    logic [7:0]  lead;
    logic [7:0]  cut;
    logic [7:0]  trail;
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [7:0]  copies;
    logic [15:0] root;
    logic [15:0] tot16;
    logic [7:0]  media;
    logic [15:0] spf;
    logic        typed;
    boot_geom_t  want;
  } sector_row_t;

  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 10;
  localparam int PHASE_BYTES = 130;
  localparam int CYCLE_LIMIT = 300000;

  // smallest legal geometry at partition 0: two clusters back from sector 0
  localparam boot_geom_t MIN_GEOM_OK = '{
    status: fbs_pkg::ST_OK, fat_lba: 33'd0, root_lba: 33'd0,
    data_lba: 34'h3_FFFF_FFFC, spc: 8'd2, copies: 8'd0,
    root_entries: 16'd0, spf: 16'd0, entries_per_cluster: 12'd32};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [32:0] out_fat_start_sector;
  logic [32:0] out_root_start_sector;
  logic signed [33:0] out_cluster_base_sector;
  logic [7:0]  out_sectors_per_cluster;
  logic [7:0]  out_fat_copies;
  logic [15:0] out_root_entry_count;
  logic [15:0] out_sectors_per_fat;
  logic [11:0] out_entries_per_cluster;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_partition_start;

  fat16_boot_sector_parser u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_data_byte            (in_data_byte),
    .in_first_byte           (in_first_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_fat_start_sector    (out_fat_start_sector),
    .out_root_start_sector   (out_root_start_sector),
    .out_cluster_base_sector (out_cluster_base_sector),
    .out_sectors_per_cluster (out_sectors_per_cluster),
    .out_fat_copies          (out_fat_copies),
    .out_root_entry_count    (out_root_entry_count),
    .out_sectors_per_fat     (out_sectors_per_fat),
    .out_entries_per_cluster (out_entries_per_cluster),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_partition_start     (cfg_partition_start)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // geometry results still owed by the block, oldest first
  boot_geom_t expected_geom_q[$];
  int         errors;
  int         parsed_bytes;
  int         cycle_count;
  bit         calm;      // no idling on either side
  bit         hold_req;  // asks the receiver for one long hold-off

  // parser shadow state
  logic [31:0]      pred_partition;
  logic [8:0]       pred_offset;
  bit               pred_done;
  logic [7:0]       pred_low;
  fbs_pkg::status_t pred_status;
  logic [7:0]       pred_spc;
  logic [15:0]      pred_rsv;
  logic [7:0]       pred_copies;
  logic [15:0]      pred_root;

  sector_row_t dir_rows[16];
  logic [31:0] partition_plan[5];

  // first failing check sticks
  task automatic note_error(input fbs_pkg::status_t code);
    if (pred_status == fbs_pkg::ST_OK)
      pred_status = code;
  endtask

  // advance the shadow parser by one accepted byte request
  task automatic parse_boot_byte(input logic [7:0] b, input logic first,
                                 output bit emitted, output boot_geom_t res);
    logic [15:0] word;
    logic [63:0] fat;
    logic [63:0] rootp;
    logic [63:0] base;
    emitted = 1'b0;
    res = '0;
    if (first) begin
      pred_offset = '0;
      pred_done = 1'b1 == 1'b0;
      pred_status = fbs_pkg::ST_OK;
    end
    if (!pred_done) begin
      parsed_bytes++;
      word = {b, pred_low};
      case (pred_offset) inside
        fbs_pkg::OFS_BPS_LO, fbs_pkg::OFS_RSV_LO, fbs_pkg::OFS_ROOT_LO,
        fbs_pkg::OFS_TOT16_LO, fbs_pkg::OFS_SPF_LO:
          pred_low = b;
        fbs_pkg::OFS_BPS_HI:
          if (word != fbs_pkg::SECTOR_BYTES) note_error(fbs_pkg::ST_BAD_SECTOR_SIZE);
        fbs_pkg::OFS_SPC: begin
          pred_spc = b;
          if (b == 8'd0 || b[0]) note_error(fbs_pkg::ST_BAD_CLUSTER);
        end
        fbs_pkg::OFS_RSV_HI:   pred_rsv = word;
        fbs_pkg::OFS_NFATS:    pred_copies = b;
        fbs_pkg::OFS_ROOT_HI:  pred_root = word;
        fbs_pkg::OFS_TOT16_HI: if (word != 16'd0) note_error(fbs_pkg::ST_SMALL_SIZE_SET);
        fbs_pkg::OFS_MEDIA:
          if (b != fbs_pkg::MEDIA_FIXED) note_error(fbs_pkg::ST_BAD_MEDIA);
        default: ;
      endcase
      if (pred_offset != 9'(fbs_pkg::OFS_SPF_HI)) begin
        pred_offset = pred_offset + 9'd1;
      end else begin
        // last field byte: one result, geometry only when every check held
        pred_done = 1'b1;
        emitted = 1'b1;
        res.status = pred_status;
        if (pred_status == fbs_pkg::ST_OK) begin
          fat = 64'(pred_partition) + 64'(pred_rsv);
          rootp = fat + 64'(pred_copies) * 64'(word);
          base = rootp - 64'(pred_spc) * 64'd2 + 64'(pred_root >> 4);
          res.fat_lba = fat[32:0];
          res.root_lba = rootp[32:0];
          res.data_lba = base[33:0];
          res.spc = pred_spc;
          res.copies = pred_copies;
          res.root_entries = pred_root;
          res.spf = word;
          res.entries_per_cluster = {pred_spc, 4'b0000};
        end
      end
    end
  endtask

  function automatic boot_geom_t fail_result(input fbs_pkg::status_t s);
    boot_geom_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  // sector byte at offset k, raw noise outside the parameter block
  function automatic logic [7:0] sector_byte(input sector_row_t r, input int k);
    case (k)
      fbs_pkg::OFS_BPS_LO:   return r.bps[7:0];
      fbs_pkg::OFS_BPS_HI:   return r.bps[15:8];
      fbs_pkg::OFS_SPC:      return r.spc;
      fbs_pkg::OFS_RSV_LO:   return r.rsv[7:0];
      fbs_pkg::OFS_RSV_HI:   return r.rsv[15:8];
      fbs_pkg::OFS_NFATS:    return r.copies;
      fbs_pkg::OFS_ROOT_LO:  return r.root[7:0];
      fbs_pkg::OFS_ROOT_HI:  return r.root[15:8];
      fbs_pkg::OFS_TOT16_LO: return r.tot16[7:0];
      fbs_pkg::OFS_TOT16_HI: return r.tot16[15:8];
      fbs_pkg::OFS_MEDIA:    return r.media;
      fbs_pkg::OFS_SPF_LO:   return r.spf[7:0];
      fbs_pkg::OFS_SPF_HI:   return r.spf[15:8];
      default:               return 8'($urandom);
    endcase
  endfunction

  // 16-bit field: edges often, otherwise small or anything
  function automatic logic [15:0] wide16();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      2, 3:    return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed sectors with random content, some broken or cut short
  function automatic sector_row_t random_sector();
    sector_row_t r;
    int pick;
    r = '0;
    r.lead  = ($urandom_range(0, 9) == 0)  ? 8'($urandom_range(1, 3)) : 8'd0;
    r.cut   = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 8'h17)) : 8'd0;
    r.trail = ($urandom_range(0, 5) == 0)  ? 8'($urandom_range(1, 6)) : 8'd0;
    r.bps   = ($urandom_range(0, 14) == 0) ? 16'($urandom) : fbs_pkg::SECTOR_BYTES;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.spc = 8'd0;
    else if (pick == 1)
      r.spc = 8'($urandom_range(0, 127) * 2 + 1);
    else if (pick < 4)
      r.spc = 8'hFE;
    else
      r.spc = 8'($urandom_range(1, 127) * 2);
    r.rsv = wide16();
    pick = $urandom_range(0, 9);
    r.copies = (pick == 0) ? 8'hFF : (pick == 1) ? 8'($urandom) : 8'($urandom_range(1, 2));
    r.root  = wide16();
    r.tot16 = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
    r.media = ($urandom_range(0, 11) == 0) ? 8'($urandom) : fbs_pkg::MEDIA_FIXED;
    r.spf   = wide16();
    return r;
  endfunction

  // offer one byte request, with a random gap ahead of it unless calm
  task automatic send_byte(input logic [7:0] d, input logic f,
                           input bit use_fixed, input boot_geom_t fixed_res);
    bit emitted;
    boot_geom_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    do @(posedge clk); while (in_stall);
    parse_boot_byte(d, f, emitted, res);
    if (emitted)
      expected_geom_q.push_back(use_fixed ? fixed_res : res);
  endtask

  task automatic send_sector(input sector_row_t r);
    int last;
    int k;
    repeat (r.lead) send_byte(8'($urandom), 1'b0, 1'b0, '0);
    last = (r.cut != 0) ? int'(r.cut) - 1 : int'(fbs_pkg::OFS_SPF_HI) + int'(r.trail);
    for (k = 0; k <= last; k++)
      send_byte(sector_byte(r, k), k == 0, r.typed && k == int'(fbs_pkg::OFS_SPF_HI),
                r.want);
  endtask

  // partition start only moves with the parser idle and every result out
  task automatic set_partition_start(input logic [31:0] v);
    @(negedge clk) in_valid <= 1'b0;
    while (expected_geom_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_partition_start <= v;
    do @(posedge clk); while (!cfg_ready);
    pred_partition = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // result side: compare every accepted request against the oldest expectation
  always @(posedge clk) begin
    boot_geom_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_geom_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        want = expected_geom_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("fat_start_sector", want.fat_lba, out_fat_start_sector);
        check_field("root_start_sector", want.root_lba, out_root_start_sector);
        check_field("cluster_base_sector", want.data_lba,
                    $unsigned(out_cluster_base_sector));
        check_field("sectors_per_cluster", want.spc, out_sectors_per_cluster);
        check_field("fat_copies", want.copies, out_fat_copies);
        check_field("root_entry_count", want.root_entries, out_root_entry_count);
        check_field("sectors_per_fat", want.spf, out_sectors_per_fat);
        check_field("entries_per_cluster", want.entries_per_cluster,
                    out_entries_per_cluster);
      end
    end
  end

  // receiver: short random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_valid            = 1'b0;
    in_data_byte        = 8'd0;
    in_first_byte       = 1'b0;
    cfg_valid           = 1'b0;
    cfg_partition_start = 32'd0;
    rst_n               = 1'b0;
    errors       = 0;
    parsed_bytes = 0;
    cycle_count  = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;

    // shadow parser after reset: idle until a first byte shows up
    pred_partition = 32'd0;
    pred_offset    = '0;
    pred_done      = 1'b1;
    pred_low       = 8'd0;
    pred_status    = fbs_pkg::ST_OK;
    pred_spc       = 8'd0;
    pred_rsv       = 16'd0;
    pred_copies    = 8'd0;
    pred_root      = 16'd0;

    // directed sectors at the reset partition start
    // lead cut trail bps spc rsv copies root tot16 media spf typed want
    dir_rows = '{
      // noise ahead of the first sector after reset is ignored; minimal geometry
      '{8'd4, 8'd0, 8'd0, 16'h0200, 8'h02, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'hF8,
        16'h0000, 1'b1, MIN_GEOM_OK},
      // every field at its top, bytes past the block ignored
      '{8'd0, 8'd0, 8'd5, 16'h0200, 8'hFE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h0000, 8'hF8,
        16'hFFFF, 1'b0, '0},
      // cluster size with the top bit set reads as unsigned
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h80, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF8,
        16'h00F0, 1'b0, '0},
      '{8'd0, 8'd0, 8'd0, 16'h0201, 8'h02, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF8,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_SECTOR_SIZE)},
      // several checks fail, sector size comes first
      '{8'd0, 8'd0, 8'd0, 16'h0000, 8'h00, 16'h0001, 8'h02, 16'h0200, 16'h0001, 8'h00,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_SECTOR_SIZE)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h00, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF8,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_CLUSTER)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h81, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF8,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_CLUSTER)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'hFF, 16'h0001, 8'h02, 16'h0200, 16'h0001, 8'hF8,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_CLUSTER)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h02, 16'h0001, 8'h02, 16'h0200, 16'h0001, 8'hF8,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_SMALL_SIZE_SET)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h02, 16'h0001, 8'h02, 16'h0200, 16'h8000, 8'h00,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_SMALL_SIZE_SET)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h02, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF0,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_MEDIA)},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h02, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF9,
        16'h0010, 1'b1, fail_result(fbs_pkg::ST_BAD_MEDIA)},
      // cut mid-block, next first byte restarts parsing
      '{8'd0, 8'h11, 8'd0, 16'h0200, 8'h00, 16'h0001, 8'h02, 16'h0200, 16'h0000, 8'hF8,
        16'h0010, 1'b0, '0},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'h04, 16'h0004, 8'h02, 16'h0200, 16'h0000, 8'hF8,
        16'h0100, 1'b0, '0},
      // cut one byte short of the result
      '{8'd0, 8'h17, 8'd0, 16'h0200, 8'h08, 16'h0002, 8'h01, 16'h0040, 16'h0000, 8'hF8,
        16'h0020, 1'b0, '0},
      '{8'd0, 8'd0, 8'd0, 16'h0200, 8'hFE, 16'h0020, 8'hFF, 16'h0010, 16'h0000, 8'hF8,
        16'h1234, 1'b0, '0}
    };
    partition_plan = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h8000_0000,
                       $urandom()};

    // hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_sector(dir_rows[i]);

    // random phases, one partition start each, extremes among them
    foreach (partition_plan[ph]) begin
      int target;
      sector_row_t tail;
      set_partition_start(partition_plan[ph]);
      if (ph == 1)
        hold_req = 1'b1;  // receiver holds off while requests keep coming
      if (ph == $size(partition_plan) - 1)
        calm = 1'b1;      // closing stretch at full rate
      target = parsed_bytes + PHASE_BYTES;
      while (parsed_bytes < target)
        send_sector(random_sector());
      // leave the parser idle before the next write
      if (!pred_done) begin
        tail = random_sector();
        tail.cut = 8'd0;
        send_sector(tail);
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (expected_geom_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
